/* design/assert_macros.svh */
// Assertion macros shared by the green-time unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds at every clock edge outside reset
`define FGT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never occurs outside reset
`define FGT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FGT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FGT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* design/fgt_pkg.sv */
// Package of types and constants for the fuzzy green-time unit
package fgt_pkg;

  localparam int CNT_W     = 16;
  localparam int TIME_W    = 24;
  localparam int STR_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_COUNT_MIN = 2'd0;
  localparam cfg_idx_t CFG_COUNT_MAX = 2'd1;
  localparam cfg_idx_t CFG_PEAK_TIME = 2'd2;

  localparam logic [CNT_W-1:0]  COUNT_MIN_RST = 16'd0;
  localparam logic [CNT_W-1:0]  COUNT_MAX_RST = 16'd100;
  localparam logic [TIME_W-1:0] PEAK_TIME_RST = 24'd289200;

  typedef enum logic [1:0] {
    TERM_LOW  = 2'd0,
    TERM_MED  = 2'd1,
    TERM_HIGH = 2'd2
  } term_t;

  typedef struct packed {
    logic [STR_W-1:0]  strength;
    term_t             term;
    logic [1:0]        pair;
    logic [TIME_W-1:0] crisp;
  } res_t;

endpackage

/* design/two_input_fuzzy_green_time_unit.sv */
// Top level of the two-input fuzzy green-time unit (Mamdani, triangular terms).
// Pipeline: one clamp stage, one divider stage per quotient bit, three inference
// stages and the output buffer; the divider sets the depth.
// Throughput: one transaction per cycle while the result side keeps up.
// Reset (rst_n low, synchronous): pipeline and output buffer empty, registers to defaults.
`include "assert_macros.svh"

module two_input_fuzzy_green_time_unit import fgt_pkg::*; #(
  parameter int NUM_TERMS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CNT_W-1:0]     in_lane_a_count,
  input  logic [CNT_W-1:0]     in_lane_b_count,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STR_W-1:0]     out_rule_strength,
  output logic [1:0]           out_time_term,
  output logic [1:0]           out_winning_pair,
  output logic [TIME_W-1:0]    out_crisp_time
);

  localparam int QI    = $clog2(NUM_TERMS);
  localparam int NUM_W = CNT_W + QI;
  localparam int QW    = QI + FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the unit is idle;
  // the block does not enforce this. Read live at every stage; unknown indexes ignored.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  count_min_r, count_min_nxt;
  logic [CNT_W-1:0]  count_max_r, count_max_nxt;
  logic [TIME_W-1:0] peak_time_r, peak_time_nxt;

  always_comb begin
    count_min_nxt = count_min_r;
    count_max_nxt = count_max_r;
    peak_time_nxt = peak_time_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT_MIN: count_min_nxt = cfg_wdata[CNT_W-1:0];
        CFG_COUNT_MAX: count_max_nxt = cfg_wdata[CNT_W-1:0];
        CFG_PEAK_TIME: peak_time_nxt = cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_min_r <= COUNT_MIN_RST;
      count_max_r <= COUNT_MAX_RST;
      peak_time_r <= PEAK_TIME_RST;
    end else begin
      count_min_r <= count_min_nxt;
      count_max_r <= count_max_nxt;
      peak_time_r <= peak_time_nxt;
    end
  end

  // Divisor of the fuzzifier; meaningless for an empty range, whose result the
  // back end overrides with index zero and no upper membership.
  logic [CNT_W-1:0] range;
  assign range = count_max_r - count_min_r;

  // ---------------------------------------------------------------------------
  // Global pipeline advance. The whole pipeline moves together and holds only
  // when the two-entry output buffer is full, so a result waiting at the output
  // never blocks the next input transaction by itself. Advance depends on
  // registered state alone, keeping out_stall off the in_stall path.
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_r, cnt_nxt;
  logic       en;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;

  // front: clamp and scale
  logic             fz_vld;
  logic             fz_empty;
  logic [NUM_W-1:0] fz_num_a;
  logic [NUM_W-1:0] fz_num_b;

  fgt_fuzz #(
    .NUM_TERMS (NUM_TERMS)
  ) u_fuzz (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid && en),
    .lane_a    (in_lane_a_count),
    .lane_b    (in_lane_b_count),
    .count_min (count_min_r),
    .count_max (count_max_r),
    .vld_o     (fz_vld),
    .empty_o   (fz_empty),
    .num_a_o   (fz_num_a),
    .num_b_o   (fz_num_b)
  );

  // divider: term index in the top bits, fraction below
  logic          dv_vld;
  logic          dv_empty;
  logic [QW-1:0] dv_q_a;
  logic [QW-1:0] dv_q_b;

  fgt_div #(
    .NUM_TERMS (NUM_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (fz_vld),
    .in_empty  (fz_empty),
    .num_a     (fz_num_a),
    .num_b     (fz_num_b),
    .range     (range),
    .out_vld   (dv_vld),
    .out_empty (dv_empty),
    .q_a       (dv_q_a),
    .q_b       (dv_q_b)
  );

  // inference and defuzzification
  logic inf_vld;
  res_t inf_res;

  fgt_infer #(
    .NUM_TERMS (NUM_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_infer (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (dv_vld),
    .in_empty  (dv_empty),
    .q_a       (dv_q_a),
    .q_b       (dv_q_b),
    .peak_time (peak_time_r),
    .out_vld   (inf_vld),
    .out_res   (inf_res)
  );

  // ---------------------------------------------------------------------------
  // Two-entry output buffer. Push whenever the pipeline advances a valid
  // result; pop on a completed output transaction. Head entry drives the ports.
  // ---------------------------------------------------------------------------
  res_t ent_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic push;
  logic pop;
  res_t head;

  assign push = en && inf_vld;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= inf_res;
    end
  end

  assign head              = ent_r[rd_ptr_r];
  assign out_valid         = (cnt_r != 2'd0);
  assign out_rule_strength = head.strength;
  assign out_time_term     = head.term;
  assign out_winning_pair  = head.pair;
  assign out_crisp_time    = head.crisp;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FGT_ASSERT(a_med_half, clk, rst_n, (out_valid && out_time_term == TERM_MED) |-> (out_crisp_time == (peak_time_r >> 1)), "medium term must give half the peak time")
  `FGT_ASSERT(a_high_above, clk, rst_n, (out_valid && out_time_term == TERM_HIGH) |-> (out_crisp_time >= (peak_time_r >> 1)), "high term below half the peak time")
  `FGT_ASSERT(a_low_below, clk, rst_n, (out_valid && out_time_term == TERM_LOW) |-> (out_crisp_time <= (peak_time_r >> 1)), "low term above half the peak time")
  `FGT_ASSERT_NEVER(a_crisp_cap, clk, rst_n, out_valid && (out_crisp_time > peak_time_r), "crisp time exceeds the peak time")
  `FGT_ASSERT(a_full_drain, clk, rst_n, (cnt_r == 2'd2 && out_valid && !out_stall) |=> (cnt_r == 2'd1), "full buffer did not drain by one")

endmodule

/* design/fgt_fuzz.sv */
// Front stage: clamp both lane counts and scale the offsets by the number of term gaps
module fgt_fuzz import fgt_pkg::*; #(
  parameter int NUM_TERMS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [CNT_W-1:0]                   lane_a,
  input  logic [CNT_W-1:0]                   lane_b,
  input  logic [CNT_W-1:0]                   count_min,
  input  logic [CNT_W-1:0]                   count_max,
  output logic                               vld_o,
  output logic                               empty_o,
  output logic [CNT_W+$clog2(NUM_TERMS)-1:0] num_a_o,
  output logic [CNT_W+$clog2(NUM_TERMS)-1:0] num_b_o
);

  localparam int QI    = $clog2(NUM_TERMS);
  localparam int NUM_W = CNT_W + QI;

  logic             vld_r, vld_nxt;
  logic             empty_r, empty_nxt;
  logic [NUM_W-1:0] num_a_r, num_a_nxt;
  logic [NUM_W-1:0] num_b_r, num_b_nxt;

  // clamp into [lo, hi] and multiply the offset by the number of term gaps
  function automatic logic [NUM_W-1:0] scale(input logic [CNT_W-1:0] x,
                                             input logic [CNT_W-1:0] lo,
                                             input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] c;
    c = x;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return NUM_W'(c - lo) * NUM_W'(NUM_TERMS - 1);
  endfunction

  always_comb begin
    vld_nxt   = in_vld;
    empty_nxt = (count_max <= count_min);
    num_a_nxt = scale(lane_a, count_min, count_max);
    num_b_nxt = scale(lane_b, count_min, count_max);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      empty_r <= empty_nxt;
      num_a_r <= num_a_nxt;
      num_b_r <= num_b_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign empty_o = empty_r;
  assign num_a_o = num_a_r;
  assign num_b_o = num_b_r;

endmodule

/* design/fgt_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two lanes abreast
module fgt_div import fgt_pkg::*; #(
  parameter int NUM_TERMS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         en,
  input  logic                                         in_vld,
  input  logic                                         in_empty,
  input  logic [CNT_W+$clog2(NUM_TERMS)-1:0]           num_a,
  input  logic [CNT_W+$clog2(NUM_TERMS)-1:0]           num_b,
  input  logic [CNT_W-1:0]                             range,
  output logic                                         out_vld,
  output logic                                         out_empty,
  output logic [$clog2(NUM_TERMS)+FRAC_BITS-1:0]       q_a,
  output logic [$clog2(NUM_TERMS)+FRAC_BITS-1:0]       q_b
);

  localparam int QI    = $clog2(NUM_TERMS);
  localparam int NUM_W = CNT_W + QI;
  localparam int QW    = QI + FRAC_BITS;

  logic [NUM_W-1:0] num [2];

  logic             vld_r   [QW];
  logic             vld_nxt [QW];
  logic             emp_r   [QW];
  logic             emp_nxt [QW];
  logic [CNT_W-1:0] rem_r   [QW][2];
  logic [CNT_W-1:0] rem_nxt [QW][2];
  logic [QI-1:0]    lo_r    [QW][2];
  logic [QI-1:0]    lo_nxt  [QW][2];
  logic [QW-1:0]    q_r     [QW][2];
  logic [QW-1:0]    q_nxt   [QW][2];

  // stage sources: the input for stage 0, the previous stage otherwise
  logic             vld_s [QW];
  logic             emp_s [QW];
  logic [CNT_W-1:0] rem_s [QW][2];
  logic [QI-1:0]    lo_s  [QW][2];
  logic [QW-1:0]    q_s   [QW][2];

  assign num[0] = num_a;
  assign num[1] = num_b;

  always_comb begin
    vld_s[0] = in_vld;
    emp_s[0] = in_empty;
    for (int l = 0; l < 2; l++) begin
      // the top bits of the dividend sit below the divisor, so start there
      rem_s[0][l] = num[l][NUM_W-1:QI];
      lo_s[0][l]  = num[l][QI-1:0];
      q_s[0][l]   = '0;
    end
    for (int j = 1; j < QW; j++) begin
      vld_s[j] = vld_r[j-1];
      emp_s[j] = emp_r[j-1];
      for (int l = 0; l < 2; l++) begin
        rem_s[j][l] = rem_r[j-1][l];
        lo_s[j][l]  = lo_r[j-1][l];
        q_s[j][l]   = q_r[j-1][l];
      end
    end
  end

  always_comb begin : p_step
    logic [CNT_W:0] t;
    logic           ge;
    t  = '0;
    ge = 1'b0;
    for (int j = 0; j < QW; j++) begin
      vld_nxt[j] = vld_s[j];
      emp_nxt[j] = emp_s[j];
      for (int l = 0; l < 2; l++) begin
        // bring down the next dividend bit; zeros follow the integer bits
        t  = {rem_s[j][l], lo_s[j][l][QI-1]};
        ge = (t >= {1'b0, range});
        rem_nxt[j][l] = ge ? CNT_W'(t - {1'b0, range}) : t[CNT_W-1:0];
        lo_nxt[j][l]  = lo_s[j][l] << 1;
        q_nxt[j][l]   = {q_s[j][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < QW; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emp_r <= emp_nxt;
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
  end

  assign out_vld   = vld_r[QW-1];
  assign out_empty = emp_r[QW-1];
  assign q_a       = q_r[QW-1][0];
  assign q_b       = q_r[QW-1][1];

endmodule

/* design/fgt_infer.sv */
// Back end: memberships, rule strengths, winner selection and defuzzification
module fgt_infer import fgt_pkg::*; #(
  parameter int NUM_TERMS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic                                   in_empty,
  input  logic [$clog2(NUM_TERMS)+FRAC_BITS-1:0] q_a,
  input  logic [$clog2(NUM_TERMS)+FRAC_BITS-1:0] q_b,
  input  logic [TIME_W-1:0]                      peak_time,
  output logic                                   out_vld,
  output res_t                                   out_res
);

  localparam int QI     = $clog2(NUM_TERMS);
  localparam int QW     = QI + FRAC_BITS;
  localparam int SW     = FRAC_BITS + 1;
  localparam int EXT_W  = (SW > STR_W) ? SW : STR_W;
  localparam int PROD_W = TIME_W + SW + 1;

  localparam logic [SW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [QW-1:0] q [2];
  logic [QI-1:0] idx [2];
  logic [SW-1:0] up [2];
  logic [SW-1:0] dn [2];

  // stage 1: memberships and pair strengths
  logic          v1_r, v1_nxt;
  logic [SW-1:0] s_r   [4];
  logic [SW-1:0] s_nxt [4];
  logic [QI-1:0] ia_r, ia_nxt;
  logic [QI-1:0] ib_r, ib_nxt;

  // stage 2: winner and rule term
  logic          v2_r, v2_nxt;
  logic [SW-1:0] bs_r, bs_nxt;
  logic [1:0]    pair_r, pair_nxt;
  term_t         term_r, term_nxt;

  // stage 3: scaled peak time
  logic              v3_r, v3_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SW-1:0]     s3_r;
  logic [1:0]        pair3_r;
  term_t             term3_r;

  logic [EXT_W-1:0]  s_ext;

  assign q[0] = q_a;
  assign q[1] = q_b;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (in_empty) begin
        idx[l] = '0;
        up[l]  = '0;
      end else if (q[l][QW-1:FRAC_BITS] == QI'(NUM_TERMS - 1)) begin
        // count at the top of the range: stay in the last gap, full upper term
        idx[l] = QI'(NUM_TERMS - 2);
        up[l]  = ONE;
      end else begin
        idx[l] = q[l][QW-1:FRAC_BITS];
        up[l]  = {1'b0, q[l][FRAC_BITS-1:0]};
      end
      dn[l] = ONE - up[l];
    end
  end

  always_comb begin : p_min
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    a = '0;
    b = '0;
    v1_nxt = in_vld;
    ia_nxt = idx[0];
    ib_nxt = idx[1];
    for (int k = 0; k < 4; k++) begin
      a = k[1] ? dn[0] : up[0];
      b = k[0] ? dn[1] : up[1];
      s_nxt[k] = (a < b) ? a : b;
    end
  end

  always_comb begin : p_pick
    logic [QI-1:0] ta;
    logic [QI-1:0] tb;
    v2_nxt   = v1_r;
    bs_nxt   = s_r[0];
    pair_nxt = 2'd0;
    // strictly greater, so the earliest pair keeps a tie
    for (int k = 1; k < 4; k++) begin
      if (s_r[k] > bs_nxt) begin
        bs_nxt   = s_r[k];
        pair_nxt = 2'(k);
      end
    end
    ta = pair_nxt[1] ? ia_r : ia_r + 1'b1;
    tb = pair_nxt[0] ? ib_r : ib_r + 1'b1;
    if (ta == tb) begin
      term_nxt = TERM_MED;
    end else if (ta < tb) begin
      term_nxt = TERM_HIGH;
    end else begin
      term_nxt = TERM_LOW;
    end
  end

  always_comb begin : p_scale
    logic [SW:0] m;
    v3_nxt = v2_r;
    unique case (term_r)
      TERM_HIGH: m = {1'b0, ONE} + {1'b0, bs_r};
      TERM_LOW:  m = {1'b0, ONE} - {1'b0, bs_r};
      default:   m = {1'b0, ONE};
    endcase
    prod_nxt = PROD_W'(peak_time) * PROD_W'(m);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= s_nxt;
      ia_r    <= ia_nxt;
      ib_r    <= ib_nxt;
      bs_r    <= bs_nxt;
      pair_r  <= pair_nxt;
      term_r  <= term_nxt;
      prod_r  <= prod_nxt;
      s3_r    <= bs_r;
      pair3_r <= pair_r;
      term3_r <= term_r;
    end
  end

  assign s_ext = EXT_W'(s3_r);

  assign out_vld          = v3_r;
  assign out_res.strength = s_ext[STR_W-1:0];
  assign out_res.term     = term3_r;
  assign out_res.pair     = pair3_r;
  // divide by twice ONE: drop FRAC_BITS+1 bits
  assign out_res.crisp    = prod_r[FRAC_BITS+1 +: TIME_W];

endmodule
